[rtl/skm_pkg.sv]
// ----------------------------------------------------------------------------
// skm_pkg
// Shared constants, codes and types of the sorted key memtable core.
// ----------------------------------------------------------------------------
package skm_pkg;

	localparam int CAPACITY  = 256;
	localparam int KEY_BITS  = 32;
	localparam int VAL_BITS  = 32;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int GRP       = 16;
	localparam int NGRP      = (CAPACITY + GRP - 1) / GRP;

	localparam logic [KEY_BITS-1:0] KEY_RESERVED = '1;

	// opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_POP    = 2'd3;

	// result status
	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_MISSING  = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_RESERVED = 3'd5;

	// cell commands
	localparam logic [2:0] CMD_NOP = 3'd0;
	localparam logic [2:0] CMD_INS = 3'd1;
	localparam logic [2:0] CMD_UPD = 3'd2;
	localparam logic [2:0] CMD_DEL = 3'd3;
	localparam logic [2:0] CMD_POP = 3'd4;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [VAL_BITS-1:0] value;
		logic                live;
	} entry_t;

	typedef struct packed {
		logic [2:0] op;
		entry_t     d;
	} cell_cmd_t;

	// value and live flag of a matching entry
	typedef logic [VAL_BITS:0] hit_data_t;

endpackage

[rtl/skm_cell.sv]
// ----------------------------------------------------------------------------
// skm_cell
// One slot of the sorted chain: holds an entry, compares it with the probe
// key, shifts with its neighbors on insert, remove and pop, and updates its value on a match.
// ----------------------------------------------------------------------------
module skm_cell
	import skm_pkg::*;
(
	input  logic                clk,
	input  cell_cmd_t           cmd,
	input  logic [KEY_BITS-1:0] probe,
	input  logic                valid,
	input  logic                left_lt,
	input  entry_t              left_d,
	input  entry_t              right_d,
	output entry_t              d,
	output logic                lt,
	output logic                eq
);

	entry_t d_q;

	assign d  = d_q;
	assign lt = valid && (d_q.key < probe);
	assign eq = valid && (d_q.key == probe);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INS: begin
				if (!lt) begin
					if (left_lt) begin
						d_q <= cmd.d;
					end else begin
						d_q <= left_d;
					end
				end
			end
			CMD_UPD: begin
				if (eq) begin
					d_q.value <= cmd.d.value;
					d_q.live  <= cmd.d.live;
				end
			end
			CMD_DEL: begin
				if (!lt) begin
					d_q <= right_d;
				end
			end
			CMD_POP: begin
				d_q <= right_d;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/skm_hit_tree.sv]
// ----------------------------------------------------------------------------
// skm_hit_tree
// Two-level registered OR tree that gathers the match flag and the payload
// of the matching cell.
// ----------------------------------------------------------------------------
module skm_hit_tree
	import skm_pkg::*;
(
	input  logic                clk,
	input  logic [CAPACITY-1:0] eq,
	input  entry_t              cell_d [CAPACITY],
	output logic                hit,
	output hit_data_t           hit_data
);

	logic      grp_hit_s1  [NGRP];
	hit_data_t grp_data_s1 [NGRP];
	logic      hit_s2;
	hit_data_t data_s2;

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			logic      h;
			hit_data_t x;
			h = 1'b0;
			x = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					if (eq[g * GRP + j]) begin
						h = 1'b1;
						x = x | {cell_d[g * GRP + j].value, cell_d[g * GRP + j].live};
					end
				end
			end
			grp_hit_s1[g]  <= h;
			grp_data_s1[g] <= x;
		end
	end

	always_ff @(posedge clk) begin
		logic      h;
		hit_data_t x;
		h = 1'b0;
		x = '0;
		for (int g = 0; g < NGRP; g++) begin
			h = h | grp_hit_s1[g];
			x = x | grp_data_s1[g];
		end
		hit_s2  <= h;
		data_s2 <= x;
	end

	assign hit      = hit_s2;
	assign hit_data = data_s2;

endmodule

[rtl/sorted_key_memtable_core.sv]
// ----------------------------------------------------------------------------
// sorted_key_memtable_core
// Ordered key store held as a sorted chain of cells.
// ----------------------------------------------------------------------------
// A request is latched in S_IDLE, passes the registered match tree of all
// cells in S_RED1 and S_RED2 and is applied in S_APPLY, where the cells
// shift or update and the result is loaded once no earlier result waits
// untaken. A new request is accepted once the previous one has been applied;
// the result register lets the next request start while a result still
// waits. Entries stay in ascending key order, slot 0 holding the smallest key.
module sorted_key_memtable_core
	import skm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], key[33:2], value_handle[65:34], live_flag[66], zero fill
	input  logic [71:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], out_key[34:3], out_live[35], out_value[67:36],
	// entry_count[76:68], least_key_seen[108:77], greatest_key_seen[140:109]
	output logic [143:0] m_tdata
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RED1  = 2'd1;
	localparam logic [1:0] S_RED2  = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0]          state_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VAL_BITS-1:0] val_q;
	logic                live_q;
	logic [CNT_BITS-1:0] count_q;
	logic [KEY_BITS-1:0] low_q;
	logic [KEY_BITS-1:0] high_q;
	logic                out_valid_q;
	logic [2:0]          o_status_q;
	logic [KEY_BITS-1:0] o_key_q;
	logic                o_live_q;
	logic [VAL_BITS-1:0] o_val_q;

	entry_t              cell_d [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] valid;
	logic                hit;
	hit_data_t           hit_data;
	cell_cmd_t           cmd;
	logic                apply;

	logic [2:0]          n_status;
	logic [KEY_BITS-1:0] n_key;
	logic                n_live;
	logic [VAL_BITS-1:0] n_val;
	logic [CNT_BITS-1:0] n_count;
	logic                n_marks;
	logic [VAL_BITS-1:0] ins_val;

	assign s_tready = (state_q == S_IDLE);
	assign apply    = (state_q == S_APPLY) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, high_q, low_q, count_q, o_val_q, o_live_q, o_key_q, o_status_q};
	assign ins_val  = live_q ? val_q : '0;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			assign valid[i] = (CNT_BITS'(i) < count_q);
			skm_cell u_cell (
				.clk     (clk),
				.cmd     (cmd),
				.probe   (key_q),
				.valid   (valid[i]),
				.left_lt (i == 0 ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
				.left_d  (i == 0 ? entry_t'('0) : cell_d[(i == 0) ? 0 : i - 1]),
				.right_d (i == CAPACITY - 1 ? entry_t'('0)
					: cell_d[(i == CAPACITY - 1) ? i : i + 1]),
				.d       (cell_d[i]),
				.lt      (lt[i]),
				.eq      (eq[i])
			);
		end
	endgenerate

	skm_hit_tree u_tree (
		.clk      (clk),
		.eq       (eq),
		.cell_d   (cell_d),
		.hit      (hit),
		.hit_data (hit_data)
	);

	// decide the operation once the match result is in
	always_comb begin
		n_status = ST_MISSING;
		n_key    = '0;
		n_live   = 1'b0;
		n_val    = '0;
		n_count  = count_q;
		n_marks  = 1'b0;
		cmd.op   = CMD_NOP;
		cmd.d    = '{key: key_q, value: ins_val, live: live_q};
		if (op_q == OP_INSERT) begin
			if (key_q == KEY_RESERVED) begin
				n_status = ST_RESERVED;
			end else if (hit || count_q != CNT_BITS'(CAPACITY)) begin
				n_marks  = 1'b1;
				n_key    = key_q;
				n_live   = live_q;
				n_val    = ins_val;
				if (hit) begin
					n_status = ST_FOUND;
					cmd.op   = CMD_UPD;
				end else begin
					n_status = ST_ADDED;
					cmd.op   = CMD_INS;
					n_count  = count_q + 1'b1;
				end
			end else begin
				n_status = ST_FULL;
			end
		end else if (count_q == '0) begin
			n_status = ST_EMPTY;
		end else if (op_q == OP_POP) begin
			n_status = ST_FOUND;
			n_key    = cell_d[0].key;
			n_live   = cell_d[0].live;
			n_val    = cell_d[0].value;
			cmd.op   = CMD_POP;
			n_count  = count_q - 1'b1;
		end else if (hit) begin
			n_status = ST_FOUND;
			n_key    = key_q;
			n_live   = hit_data[0];
			n_val    = hit_data[VAL_BITS:1];
			if (op_q == OP_REMOVE) begin
				cmd.op  = CMD_DEL;
				n_count = count_q - 1'b1;
			end
		end
		if (!apply) begin
			cmd.op = CMD_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			low_q       <= '1;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_RED1;
					end
				end
				S_RED1: begin
					state_q <= S_RED2;
				end
				S_RED2: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply) begin
						state_q     <= S_IDLE;
						count_q     <= n_count;
						if (n_marks && key_q < low_q) begin
							low_q <= key_q;
						end
						if (n_marks && key_q > high_q) begin
							high_q <= key_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tdata[1:0];
			key_q  <= s_tdata[33:2];
			val_q  <= s_tdata[65:34];
			live_q <= s_tdata[66];
		end
		if (apply) begin
			o_status_q <= n_status;
			o_key_q    <= n_key;
			o_live_q   <= n_live;
			o_val_q    <= n_val;
		end
	end

endmodule
